// ===== rtl/core/ula_pkg.sv =====
// Shared types and constants of the UART line assembler ring.
package ula_pkg;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TAKE  = 2'd1,
		OP_ERROR = 2'd2
	} opcode_t;

	localparam logic [1:0] CFG_TERMINATOR = 2'd0;
	localparam logic [1:0] CFG_LINES      = 2'd1;
	localparam logic [1:0] CFG_LENGTH     = 2'd2;

	localparam logic [7:0] RST_TERMINATOR = 8'd10;
	localparam logic [4:0] RST_LINES      = 5'd16;
	localparam logic [5:0] RST_LENGTH     = 6'd32;

	localparam logic [7:0] CR_BYTE   = 8'h0D;
	localparam int         MARK_ROOM = 2;
	localparam int         MAX_TAKE  = 30;
	localparam int         MIN_LEN   = 3;

endpackage

// ===== rtl/core/uart_line_assembler_ring.sv =====
// UART line assembler over a ring of line buffers kept in one synchronous RAM.
//
// Item channel (item_valid / item_stall) carries opcode and rx_byte:
//   OP_BYTE  - store rx_byte in the current line; one result, line_done set when
//              the byte (terminator, CR or full line) closed the line.
//   OP_TAKE  - emit the oldest closed line one character per result, last on
//              the final one; a single no_line result when the ring is empty.
//   OP_ERROR - bump the wrapping receive error counter; one result.
// Result channel (result_valid / result_stall) is a single output register;
// error_count shows the current counter with every result.
// A byte that closes a line also holds the input while ST_MARK writes the zero
// marker (a second write on the single RAM write port); other bytes and error
// events hold it only while a result stalls. A take holds the input until its
// line is out: the accepting cycle reads the first byte, ST_FIRST catches it
// and reads ahead, then ST_NEXT gives one character per result; a line that
// starts with a zero byte gets one result with no character from ST_FIRST. A
// byte, error or no_line result appears in the cycle after acceptance.
// Config writes (cfg_valid / cfg_ready, always ready) are taken any cycle.
// Reset empties the ring and clears the counter; RAM contents are kept. A
// stalled result holds, and no new item is taken until it leaves.
module uart_line_assembler_ring
	import ula_pkg::*;
#(
	parameter int NUM_LINES = 16,
	parameter int LINE_SIZE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        line_done,
	output logic [3:0]  done_line_index,
	output logic [7:0]  out_char,
	output logic        char_valid,
	output logic        no_line,
	output logic        last,
	output logic [31:0] error_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int PW    = $clog2(LINE_SIZE);
	localparam int AW    = LW + PW;
	localparam int DEPTH = NUM_LINES * (2 ** PW);
	localparam int MAXN  = (LINE_SIZE < MAX_TAKE) ? LINE_SIZE : MAX_TAKE;
	localparam int TW    = $clog2(MAXN + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MARK,
		ST_FIRST,
		ST_NEXT
	} state_t;

	// Configuration registers
	logic [7:0] terminator_q;
	logic [4:0] lines_in_use_q;
	logic [5:0] line_length_q;

	// Control state
	state_t          state_q;
	logic [LW-1:0]   write_line_q;
	logic [PW-1:0]   char_pos_q;
	logic [LW-1:0]   take_line_q;
	logic [TW-1:0]   tk_pos_q;
	logic [31:0]     err_q;
	logic [AW-1:0]   mark_addr_q;
	logic [7:0]      cur_q;

	// Result register
	logic            out_vld_q;
	logic            line_done_q;
	logic [3:0]      done_idx_q;
	logic [7:0]      out_char_q;
	logic            char_valid_q;
	logic            no_line_q;
	logic            last_q;

	// Line RAM
	logic [7:0]      line_mem [DEPTH];
	logic [7:0]      rd_data_q;
	logic            mem_we;
	logic [AW-1:0]   mem_wr_addr;
	logic [7:0]      mem_wr_data;
	logic [AW-1:0]   mem_rd_addr;

	// Derived control
	logic            out_free;
	logic            item_acc;
	logic [8:0]      eff_lines;
	logic [6:0]      eff_len;
	logic [6:0]      limit;
	logic [PW-1:0]   char_pos_inc;
	logic            close_line;
	logic [8:0]      wl_ext;
	logic            lastc;
	logic            tk_step;
	logic [TW-1:0]   rd_pos;

	function automatic logic [LW-1:0] next_line(input logic [LW-1:0] cur,
			input logic [8:0] lines);
		logic [8:0] n;
		n = 9'(cur) + 9'd1;
		return (n >= lines) ? '0 : LW'(n);
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terminator_q   <= RST_TERMINATOR;
			lines_in_use_q <= RST_LINES;
			line_length_q  <= RST_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TERMINATOR: terminator_q   <= cfg_data;
				CFG_LINES:      lines_in_use_q <= cfg_data[4:0];
				CFG_LENGTH:     line_length_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Clamp the ring size and line length to what the RAM holds
	always_comb begin
		eff_lines = 9'(lines_in_use_q);
		if (eff_lines < 9'd1) eff_lines = 9'd1;
		if (eff_lines > 9'(NUM_LINES)) eff_lines = 9'(NUM_LINES);
		eff_len = 7'(line_length_q);
		if (eff_len < 7'(MIN_LEN)) eff_len = 7'(MIN_LEN);
		if (eff_len > 7'(LINE_SIZE)) eff_len = 7'(LINE_SIZE);
	end

	assign limit        = eff_len - 7'(MARK_ROOM);
	assign char_pos_inc = char_pos_q + PW'(1);
	// Close on terminator, CR, or when the line has reached its character limit
	assign close_line   = (rx_byte == terminator_q) || (rx_byte == CR_BYTE) ||
		(7'(char_pos_inc) >= limit);
	assign wl_ext       = 9'(write_line_q);

	assign out_free   = !out_vld_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE) || !out_free;
	assign item_acc   = item_valid && !item_stall;

	// Current character is the last one when the next is the zero marker or
	// the take has reached its character cap
	assign lastc   = (tk_pos_q == TW'(MAXN)) || (rd_data_q == 8'd0);
	assign tk_step = ((state_q == ST_FIRST) && (rd_data_q != 8'd0)) ||
		((state_q == ST_NEXT) && out_free && !lastc);

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_pos = '0;
		end else if (tk_step) begin
			rd_pos = tk_pos_q + TW'(1);
		end else begin
			rd_pos = tk_pos_q;
		end
	end

	assign mem_rd_addr = {take_line_q, PW'(rd_pos)};
	assign mem_we      = (state_q == ST_MARK) ||
		(item_acc && (opcode_t'(opcode) == OP_BYTE));
	assign mem_wr_addr = (state_q == ST_MARK) ? mark_addr_q : {write_line_q, char_pos_q};
	assign mem_wr_data = (state_q == ST_MARK) ? 8'd0 : rx_byte;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_wr_addr] <= mem_wr_data;
		end
		rd_data_q <= line_mem[mem_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_vld_q    <= 1'b0;
			write_line_q <= '0;
			char_pos_q   <= '0;
			take_line_q  <= '0;
			tk_pos_q     <= '0;
			err_q        <= '0;
			mark_addr_q  <= '0;
			cur_q        <= '0;
			line_done_q  <= 1'b0;
			done_idx_q   <= '0;
			out_char_q   <= '0;
			char_valid_q <= 1'b0;
			no_line_q    <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			// Drop the result once taken; a new load below overrides this
			if (out_vld_q && !result_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						line_done_q  <= 1'b0;
						done_idx_q   <= '0;
						out_char_q   <= '0;
						char_valid_q <= 1'b0;
						no_line_q    <= 1'b0;
						last_q       <= 1'b1;
						case (opcode_t'(opcode))
							OP_BYTE: begin
								out_vld_q <= 1'b1;
								if (close_line) begin
									line_done_q  <= 1'b1;
									done_idx_q   <= wl_ext[3:0];
									mark_addr_q  <= {write_line_q, char_pos_inc};
									write_line_q <= next_line(write_line_q, eff_lines);
									char_pos_q   <= '0;
									state_q      <= ST_MARK;
								end else begin
									char_pos_q <= char_pos_inc;
								end
							end
							OP_TAKE: begin
								if (take_line_q == write_line_q) begin
									out_vld_q <= 1'b1;
									no_line_q <= 1'b1;
								end else begin
									tk_pos_q <= '0;
									state_q  <= ST_FIRST;
								end
							end
							OP_ERROR: begin
								out_vld_q <= 1'b1;
								err_q     <= err_q + 32'd1;
							end
							default: begin
								out_vld_q <= 1'b1;
							end
						endcase
					end
				end
				ST_MARK: begin
					state_q <= ST_IDLE;
				end
				ST_FIRST: begin
					if (rd_data_q == 8'd0) begin
						// Empty line: one result with no character
						if (out_free) begin
							out_vld_q    <= 1'b1;
							line_done_q  <= 1'b0;
							done_idx_q   <= '0;
							out_char_q   <= '0;
							char_valid_q <= 1'b0;
							no_line_q    <= 1'b0;
							last_q       <= 1'b1;
							take_line_q  <= next_line(take_line_q, eff_lines);
							state_q      <= ST_IDLE;
						end
					end else begin
						cur_q    <= rd_data_q;
						tk_pos_q <= TW'(1);
						state_q  <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (out_free) begin
						out_vld_q    <= 1'b1;
						line_done_q  <= 1'b0;
						done_idx_q   <= '0;
						out_char_q   <= cur_q;
						char_valid_q <= 1'b1;
						no_line_q    <= 1'b0;
						last_q       <= lastc;
						if (lastc) begin
							take_line_q <= next_line(take_line_q, eff_lines);
							state_q     <= ST_IDLE;
						end else begin
							cur_q    <= rd_data_q;
							tk_pos_q <= tk_pos_q + TW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid    = out_vld_q;
	assign line_done       = line_done_q;
	assign done_line_index = done_idx_q;
	assign out_char        = out_char_q;
	assign char_valid      = char_valid_q;
	assign no_line         = no_line_q;
	assign last            = last_q;
	assign error_count     = err_q;

endmodule

// ===== tb/sv/tb_uart_line_assembler_ring.sv =====
// Self-checking testbench of the UART line assembler ring, with its own line ring predictor.
`timescale 1ns / 100ps

module tb_uart_line_assembler_ring;
	import ula_pkg::*;

	localparam int RING_LINES  = 16;
	localparam int LINE_BYTES  = 32;
	localparam int QUIET_LIMIT = 400;
	localparam int SETTLE_CYCLES = 4;

	// Codes outside the defined sets: the opcode gets a plain result, the config write is dropped.
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam logic [1:0] CFG_SPARE  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} rx_item_t;

	typedef struct packed {
		logic        line_done;
		logic [3:0]  done_line_index;
		logic [7:0]  out_char;
		logic        char_valid;
		logic        no_line;
		logic        last;
		logic [31:0] error_count;
	} ring_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  opcode = OP_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        line_done;
	logic [3:0]  done_line_index;
	logic [7:0]  out_char;
	logic        char_valid;
	logic        no_line;
	logic        last;
	logic [31:0] error_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_TERMINATOR;
	logic [7:0]  cfg_data = 8'h00;

	uart_line_assembler_ring #(
		.NUM_LINES(RING_LINES),
		.LINE_SIZE(LINE_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.line_done(line_done),
		.done_line_index(done_line_index),
		.out_char(out_char),
		.char_valid(char_valid),
		.no_line(no_line),
		.last(last),
		.error_count(error_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Items waiting for the driver, and line ring results still owed by the block.
	rx_item_t     rx_stream[$];
	ring_result_t line_events_due[$];

	int items_queued   = 0;
	int items_accepted = 0;
	int mismatches     = 0;
	logic item_taken   = 1'b0;
	logic calm         = 1'b0;   // set for the final phase: no gaps, no stalls

	// Predictor copy of the ring: line bytes, pointers, error counter and registers.
	logic [7:0]  line_mem [RING_LINES][LINE_BYTES];
	int          wr_line    = 0;
	int          wr_pos     = 0;
	int          rd_line    = 0;
	logic [31:0] rx_errors  = '0;
	logic [7:0]  reg_term   = RST_TERMINATOR;
	logic [4:0]  reg_lines  = RST_LINES;
	logic [5:0]  reg_length = RST_LENGTH;

	initial begin
		forever #6 clk = ~clk;
	end

	// Step to the next line, wrapping at the number of lines in use (clamped 1..RING_LINES).
	function automatic int ring_next(int cur);
		int span;
		span = (reg_lines == 5'd0) ? 1 :
			((int'(reg_lines) > RING_LINES) ? RING_LINES : int'(reg_lines));
		return (cur + 1 >= span) ? 0 : cur + 1;
	endfunction

	// Apply one accepted transaction to the predictor and queue the results it owes.
	task automatic model_line_ring(logic [1:0] op, logic [7:0] b);
		ring_result_t r;
		int limit;
		int n;
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_BYTE: begin
				limit = (reg_length < MIN_LEN) ? MIN_LEN :
					((int'(reg_length) > LINE_BYTES) ? LINE_BYTES : int'(reg_length));
				limit = limit - MARK_ROOM;
				line_mem[wr_line][wr_pos] = b;
				wr_pos++;
				// Close on terminator, CR, or a full line; a shrunk length closes at once.
				if (b == reg_term || b == CR_BYTE || wr_pos >= limit) begin
					line_mem[wr_line][wr_pos] = 8'h00;
					r.line_done = 1'b1;
					r.done_line_index = 4'(wr_line);
					wr_line = ring_next(wr_line);
					wr_pos = 0;
				end
				r.error_count = rx_errors;
				line_events_due.push_back(r);
			end
			OP_TAKE: begin
				r.error_count = rx_errors;
				if (rd_line == wr_line) begin
					r.no_line = 1'b1;
					line_events_due.push_back(r);
				end else begin
					n = 0;
					while (n < MAX_TAKE && n < LINE_BYTES && line_mem[rd_line][n] != 8'h00)
						n++;
					// A line that starts with a zero byte still yields one empty result.
					if (n == 0)
						line_events_due.push_back(r);
					for (int i = 0; i < n; i++) begin
						r.out_char = line_mem[rd_line][i];
						r.char_valid = 1'b1;
						r.last = (i + 1 == n);
						line_events_due.push_back(r);
					end
					rd_line = ring_next(rd_line);
				end
			end
			OP_ERROR: begin
				rx_errors = rx_errors + 32'd1;
				r.error_count = rx_errors;
				line_events_due.push_back(r);
			end
			default: begin
				r.error_count = rx_errors;
				line_events_due.push_back(r);
			end
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: present the next transaction at the falling edge once the last one is gone.
	// A gap burst may only follow a transaction, so gaps never chain.
	int send_gap = 0;
	always @(negedge clk) begin
		rx_item_t cur;
		if (arst_n && (!item_valid || item_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (rx_stream.size() != 0 &&
				(calm || !item_valid || $urandom_range(0, 5) != 0)) begin
				cur = rx_stream.pop_front();
				item_valid <= 1'b1;
				opcode <= cur.op;
				rx_byte <= cur.data;
			end else if (rx_stream.size() != 0) begin
				send_gap = $urandom_range(0, 7);
				item_valid <= 1'b0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall in random bursts, always releasing in between.
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (!result_stall && !calm && $urandom_range(0, 4) == 0) begin
			hold_left = $urandom_range(0, 7);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Monitor: check each result transaction, then predict from each input transaction.
	always @(posedge clk) begin
		ring_result_t want;
		item_taken <= item_valid && !item_stall;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (line_events_due.size() == 0) begin
					$error("result with nothing expected: char %0h, done %0b, last %0b",
						out_char, line_done, last);
					mismatches++;
				end else begin
					want = line_events_due.pop_front();
					check_field("line_done", 32'(want.line_done), 32'(line_done));
					check_field("done_line_index", 32'(want.done_line_index),
						32'(done_line_index));
					check_field("out_char", 32'(want.out_char), 32'(out_char));
					check_field("char_valid", 32'(want.char_valid), 32'(char_valid));
					check_field("no_line", 32'(want.no_line), 32'(no_line));
					check_field("last", 32'(want.last), 32'(last));
					check_field("error_count", want.error_count, error_count);
				end
			end
			if (item_valid && !item_stall) begin
				model_line_ring(opcode, rx_byte);
				items_accepted++;
			end
		end
	end

	// Watchdog: end the run after too many cycles with no transaction on any channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("uart_line_assembler_ring: mismatch");
		$finish;
	end

	task automatic send(logic [1:0] op, logic [7:0] b);
		rx_stream.push_back('{op: op, data: b});
		items_queued++;
	endtask

	// Hold until every queued item is in and every owed result is out, then let the
	// block finish any trailing marker write.
	task automatic settle();
		while (items_accepted != items_queued || line_events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_TERMINATOR: reg_term = value;
			CFG_LINES:      reg_lines = value[4:0];
			CFG_LENGTH:     reg_length = value[5:0];
			default:        ;
		endcase
	endtask

	// Drain the ring before touching the registers, so a ring resize never points the
	// reader at a line that was never written. A partly filled line is kept on purpose.
	task automatic reconfigure(logic [7:0] term, logic [7:0] lines, logic [7:0] length);
		settle();
		while (rd_line != wr_line) begin
			send(OP_TAKE, 8'($urandom));
			settle();
		end
		write_reg(CFG_TERMINATOR, term);
		write_reg(CFG_LINES, lines);
		write_reg(CFG_LENGTH, length);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic, mostly line bytes with terminators, CRs and zero bytes mixed in,
	// then takes and error events. Ignored opcodes ride along but do not count.
	task automatic queue_traffic(int count);
		int kept;
		int pick;
		logic [7:0] b;
		kept = 0;
		while (kept < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				case ($urandom_range(0, 15))
					0:       b = reg_term;
					1:       b = CR_BYTE;
					2:       b = 8'h00;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send(OP_BYTE, b);
				kept++;
			end else if (pick < 88) begin
				send(OP_TAKE, 8'($urandom));
				kept++;
			end else if (pick < 96) begin
				send(OP_ERROR, 8'($urandom));
				kept++;
			end else begin
				send(OP_IGNORED, 8'($urandom));
			end
		end
	endtask

	initial begin
		for (int l = 0; l < RING_LINES; l++)
			for (int p = 0; p < LINE_BYTES; p++)
				line_mem[l][p] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty take, error event, ignored opcode, then lines closed by the
		// terminator, by a lone CR, and one led by a zero byte; take them all back.
		send(OP_TAKE, 8'h00);
		send(OP_ERROR, 8'hFF);
		send(OP_IGNORED, 8'h5C);
		send(OP_BYTE, 8'h41);
		send(OP_BYTE, 8'hFF);
		send(OP_BYTE, RST_TERMINATOR);
		send(OP_BYTE, CR_BYTE);
		send(OP_BYTE, 8'h00);
		send(OP_BYTE, 8'h7E);
		send(OP_BYTE, CR_BYTE);
		repeat (4) send(OP_TAKE, 8'($urandom));

		// Shortest line: every byte closes its own line. Upper data bits must be dropped.
		reconfigure(8'h5A, 8'hE4, 8'h00);
		send(OP_BYTE, 8'h55);
		send(OP_BYTE, 8'hAA);
		send(OP_BYTE, 8'h5A);
		repeat (4) send(OP_TAKE, 8'($urandom));

		// Random phases across terminators, ring sizes and lengths, extremes included.
		reconfigure(RST_TERMINATOR, 8'd16, 8'd32);
		queue_traffic(50);
		reconfigure(8'hFF, 8'h00, 8'h3F);
		queue_traffic(45);
		reconfigure(8'h00, 8'h01, 8'h03);
		queue_traffic(40);
		reconfigure(8'($urandom), 8'hFF, 8'hC2);
		queue_traffic(55);
		reconfigure(8'($urandom), 8'h04, 8'h08);
		write_reg(CFG_SPARE, 8'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		queue_traffic(55);

		// Last phase at full rate on both sides.
		calm = 1'b1;
		reconfigure(8'($urandom_range(32, 126)), 8'h11, 8'h21);
		queue_traffic(55);
		settle();

		if (mismatches == 0)
			$display("uart_line_assembler_ring: match");
		else
			$display("uart_line_assembler_ring: mismatch");
		$finish;
	end

endmodule
